@@ rtl/elg_pkg.sv @@
// Shared widths, constants, value types and the stage type of the elevation gain and loss tracker.
package elg_pkg;

    localparam int ELEV_W     = 20;
    localparam int TOTAL_W    = 40;
    localparam int SUM_W      = 24;
    localparam int IDX_W      = 5;
    localparam int WINDOW_DEF = 5;

    localparam logic signed [ELEV_W-1:0] MAX_RESTART = -20'sd8;
    localparam logic [TOTAL_W-1:0]       TOTAL_MAX   = {TOTAL_W{1'b1}};

    typedef logic signed [ELEV_W-1:0]  t_elev;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic [TOTAL_W-1:0]        t_total;

    typedef struct packed {
        logic  valid;
        logic  route_start;
        logic  active;
        logic  first;
        t_sum  sum;
        t_elev max_elev;
    } t_stage;

endpackage

@@ rtl/elg_if.sv @@
// Request channels of the elevation tracker: sample input and statistics output.
interface elg_in_if;
    logic                        valid;
    logic                        ready;
    logic signed [elg_pkg::ELEV_W-1:0] elevation;
    logic                        route_start;

    modport source (output valid, output elevation, output route_start, input ready);
    modport sink   (input valid, input elevation, input route_start, output ready);
endinterface

interface elg_out_if;
    logic                         valid;
    logic                         ready;
    logic signed [elg_pkg::ELEV_W-1:0]  max_elevation;
    logic [elg_pkg::TOTAL_W-1:0]        gain_total;
    logic [elg_pkg::TOTAL_W-1:0]        loss_total;
    logic                         averaging_active;

    modport source (output valid, output max_elevation, output gain_total,
                    output loss_total, output averaging_active, input ready);
    modport sink   (input valid, input max_elevation, input gain_total,
                    input loss_total, input averaging_active, output ready);
endinterface

@@ rtl/elg_cell.sv @@
// One history cell: holds a sample (or zero when cleared) and hands it to the next cell on each advance.
module elg_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_clr,
    input  elg_pkg::t_elev i_d,
    output elg_pkg::t_elev o_q
);

    elg_pkg::t_elev r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_en) begin
            r_q <= i_clr ? '0 : i_d;
        end
    end

    assign o_q = r_q;

endmodule

@@ rtl/elg_accum.sv @@
// Second stage: gain and loss accumulation against the previous window sum.
module elg_accum (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  elg_pkg::t_stage  i_stage,
    output logic             o_valid,
    output elg_pkg::t_elev   o_max_elevation,
    output elg_pkg::t_total  o_gain_total,
    output elg_pkg::t_total  o_loss_total,
    output logic             o_averaging_active
);

    logic            r_valid;
    logic            r_active;
    elg_pkg::t_elev  r_max;
    elg_pkg::t_total r_gain;
    elg_pkg::t_total r_loss;
    elg_pkg::t_sum   r_prev;

    elg_pkg::t_sum   prev_eff;
    elg_pkg::t_total gain_base;
    elg_pkg::t_total loss_base;
    logic signed [elg_pkg::SUM_W:0]   diff;
    logic [elg_pkg::SUM_W:0]          mag;
    logic                             rise;
    logic [elg_pkg::TOTAL_W:0]        acc_sum;
    elg_pkg::t_total                  acc_sat;
    elg_pkg::t_total                  n_gain;
    elg_pkg::t_total                  n_loss;

    always_comb begin
        prev_eff  = i_stage.first ? i_stage.sum : r_prev;
        gain_base = i_stage.route_start ? '0 : r_gain;
        loss_base = i_stage.route_start ? '0 : r_loss;
        diff      = {i_stage.sum[elg_pkg::SUM_W-1], i_stage.sum}
                  - {prev_eff[elg_pkg::SUM_W-1], prev_eff};
        rise      = diff > 0;
        mag       = rise ? $unsigned(diff) : $unsigned(-diff);
        acc_sum   = {1'b0, rise ? gain_base : loss_base}
                  + {{(elg_pkg::TOTAL_W - elg_pkg::SUM_W){1'b0}}, mag};
        acc_sat   = acc_sum[elg_pkg::TOTAL_W] ? elg_pkg::TOTAL_MAX
                                              : acc_sum[elg_pkg::TOTAL_W-1:0];
        n_gain    = gain_base;
        n_loss    = loss_base;
        if (i_stage.active) begin
            if (rise) begin
                n_gain = acc_sat;
            end else begin
                n_loss = acc_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_gain  <= '0;
            r_loss  <= '0;
            r_prev  <= '0;
        end else if (i_en) begin
            r_valid <= i_stage.valid;
            if (i_stage.valid) begin
                r_gain <= n_gain;
                r_loss <= n_loss;
                if (i_stage.active) begin
                    r_prev <= i_stage.sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_stage.valid) begin
            r_max    <= i_stage.max_elev;
            r_active <= i_stage.active;
        end
    end

    assign o_valid            = r_valid;
    assign o_max_elevation    = r_max;
    assign o_gain_total       = r_gain;
    assign o_loss_total       = r_loss;
    assign o_averaging_active = r_active;

endmodule

@@ rtl/elevation_gain_loss_tracker.sv @@
// Top level: cell chain, window sum and running maximum, then accumulation stage.
// Pipeline: 2 register stages; a request passes through the stage register into the output register.
// Throughput: 1 request per cycle while not stalled; the window sum is kept incrementally
// across the cell chain. Backpressure stalls both stages together; the input is ready
// whenever the output register is empty or being taken.
// Reset (synchronous, active low) clears history, index, totals and sets the maximum to -8.
module elevation_gain_loss_tracker #(
    parameter int WINDOW = elg_pkg::WINDOW_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    elg_in_if.sink    i_in,
    elg_out_if.source o_out
);

    logic                         en;
    logic                         accept;
    elg_pkg::t_elev               chain [0:WINDOW-1];
    elg_pkg::t_sum                e_ext;
    elg_pkg::t_sum                last_ext;
    elg_pkg::t_sum                hist_base;
    logic [elg_pkg::IDX_W-1:0]    cur_idx;
    logic [elg_pkg::IDX_W-1:0]    n_idx;
    elg_pkg::t_elev               cur_max;
    elg_pkg::t_elev               n_max;
    elg_pkg::t_stage              n_stage;

    logic [elg_pkg::IDX_W-1:0]    r_idx;
    elg_pkg::t_elev               r_max;
    elg_pkg::t_sum                r_hist;
    elg_pkg::t_stage              r_stage;

    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;
    assign accept     = i_in.valid && en;
    assign chain[0]   = i_in.elevation;

    for (genvar g = 0; g < WINDOW - 1; g++) begin : g_cell
        elg_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (accept),
            .i_clr   (i_in.route_start && (g != 0)),
            .i_d     (chain[g]),
            .o_q     (chain[g+1])
        );
    end

    always_comb begin
        e_ext     = elg_pkg::t_sum'(i_in.elevation);
        last_ext  = i_in.route_start ? '0 : elg_pkg::t_sum'(chain[WINDOW-1]);
        hist_base = i_in.route_start ? '0 : r_hist;
        cur_idx   = i_in.route_start ? '0 : r_idx;
        cur_max   = i_in.route_start ? elg_pkg::MAX_RESTART : r_max;
        n_max     = (i_in.elevation > cur_max) ? i_in.elevation : cur_max;
        n_idx     = (cur_idx <= elg_pkg::IDX_W'(WINDOW)) ? cur_idx + elg_pkg::IDX_W'(1)
                                                         : cur_idx;

        n_stage.valid       = i_in.valid;
        n_stage.route_start = i_in.route_start;
        n_stage.active      = cur_idx >= elg_pkg::IDX_W'(WINDOW);
        n_stage.first       = cur_idx == elg_pkg::IDX_W'(WINDOW);
        n_stage.sum         = e_ext + hist_base;
        n_stage.max_elev    = n_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx         <= '0;
            r_max         <= elg_pkg::MAX_RESTART;
            r_hist        <= '0;
            r_stage.valid <= 1'b0;
        end else if (en) begin
            if (i_in.valid) begin
                r_idx   <= n_idx;
                r_max   <= n_max;
                r_hist  <= hist_base + e_ext - last_ext;
                r_stage <= n_stage;
            end else begin
                r_stage.valid <= 1'b0;
            end
        end
    end

    elg_accum u_accum (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_en               (en),
        .i_stage            (r_stage),
        .o_valid            (o_out.valid),
        .o_max_elevation    (o_out.max_elevation),
        .o_gain_total       (o_out.gain_total),
        .o_loss_total       (o_out.loss_total),
        .o_averaging_active (o_out.averaging_active)
    );

endmodule

@@ rtl/elg_checker.sv @@
// Port-level assertions for the elevation tracker, bound to the top level.
module elg_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input elg_pkg::t_elev  i_max_elevation,
    input elg_pkg::t_total i_gain_total,
    input elg_pkg::t_total i_loss_total,
    input logic            i_averaging_active
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_gain_total) && $stable(i_loss_total)
                                        && $stable(i_max_elevation))
        else $error("output payload changed while stalled");

    a_idle_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_averaging_active |-> i_gain_total == '0 && i_loss_total == '0)
        else $error("totals nonzero before averaging starts");

    a_max_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_max_elevation >= elg_pkg::MAX_RESTART)
        else $error("maximum below restart value");

    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind elevation_gain_loss_tracker elg_checker u_elg_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_max_elevation    (o_out.max_elevation),
    .i_gain_total       (o_out.gain_total),
    .i_loss_total       (o_out.loss_total),
    .i_averaging_active (o_out.averaging_active)
);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the elevation tracker: random and directed samples, predicted statistics.
module testbench;

    localparam int WINDOW     = elg_pkg::WINDOW_DEF;
    localparam int N_RANDOM   = 1750;
    localparam int IDLE_PCT   = 21;
    localparam int CALM_FROM  = 700;
    localparam int CALM_TO    = 1000;
    localparam int STALL_MAX  = 2000;
    localparam int DRAIN_CYC  = 8;

    typedef struct {
        elg_pkg::t_elev elevation;
        logic           route_start;
    } t_sample;

    typedef struct {
        elg_pkg::t_elev  max_elevation;
        elg_pkg::t_total gain_total;
        elg_pkg::t_total loss_total;
        logic            averaging_active;
    } t_stats;

    logic i_clk;
    logic i_rst_n;

    elg_in_if  in_ch ();
    elg_out_if out_ch ();

    elevation_gain_loss_tracker #(.WINDOW(WINDOW)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_sample pending_samples[$];
    t_stats  stats_due[$];
    int      n_errors;
    int      n_sent;
    int      idle_cycles;
    logic    calm;

    elg_pkg::t_elev             hist[WINDOW-1];
    logic [elg_pkg::IDX_W-1:0]  route_idx;
    elg_pkg::t_sum              prev_window;
    elg_pkg::t_elev             peak;
    elg_pkg::t_total            gain_acc;
    elg_pkg::t_total            loss_acc;

    function automatic void restart_route();
        foreach (hist[i]) hist[i] = '0;
        route_idx   = '0;
        prev_window = '0;
        peak        = elg_pkg::MAX_RESTART;
        gain_acc    = '0;
        loss_acc    = '0;
    endfunction

    function automatic elg_pkg::t_total add_clamped(elg_pkg::t_total acc, logic [31:0] delta);
        logic [elg_pkg::TOTAL_W:0] s;
        s = {1'b0, acc} + delta;
        return (s > {1'b0, elg_pkg::TOTAL_MAX}) ? elg_pkg::TOTAL_MAX
                                                : s[elg_pkg::TOTAL_W-1:0];
    endfunction

    function automatic t_stats track_sample(elg_pkg::t_elev e, logic start);
        logic signed [31:0] win;
        logic               active;
        t_stats             r;
        if (start) restart_route();
        if (e > peak) peak = e;
        active = (route_idx >= WINDOW);
        if (active) begin
            win = e;
            foreach (hist[i]) win += hist[i];
            if (route_idx == WINDOW) prev_window = win[elg_pkg::SUM_W-1:0];
            if (win > prev_window)
                gain_acc = add_clamped(gain_acc, win - prev_window);
            else
                loss_acc = add_clamped(loss_acc, prev_window - win);
            prev_window = win[elg_pkg::SUM_W-1:0];
        end
        for (int i = WINDOW - 2; i > 0; i--) hist[i] = hist[i-1];
        hist[0] = e;
        if (route_idx <= WINDOW) route_idx++;
        r.max_elevation    = peak;
        r.gain_total       = gain_acc;
        r.loss_total       = loss_acc;
        r.averaging_active = active;
        return r;
    endfunction

    task automatic add_sample(int e, logic start);
        t_sample s;
        s.elevation   = e[elg_pkg::ELEV_W-1:0];
        s.route_start = start;
        pending_samples.push_back(s);
    endtask

    task automatic add_route();
        int mode;
        int len;
        int span;
        int cur;
        logic start;
        mode  = $urandom_range(9);
        len   = ($urandom_range(7) == 0) ? $urandom_range(1, 5) : $urandom_range(6, 80);
        start = ($urandom_range(7) != 0);
        case ($urandom_range(3))
            0: span = 0;
            1: span = 3;
            2: span = 64;
            default: span = 4096;
        endcase
        cur = int'($urandom_range(0, 1048575)) - 524288;
        for (int k = 0; k < len; k++) begin
            if (mode <= 5) begin
                cur += int'($urandom_range(0, 2 * span)) - span;
                if (cur > 524287) cur = 524287;
                if (cur < -524288) cur = -524288;
            end else if (mode <= 7) begin
                cur = int'($urandom_range(0, 1048575)) - 524288;
            end else if (mode == 8) begin
                cur = $urandom_range(1) ? 524287 : -524288;
            end else begin
                cur = int'($urandom_range(0, 24)) - 16;
            end
            add_sample(cur, (k == 0) ? start : 1'b0);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    assign calm = (n_sent >= CALM_FROM) && (n_sent < CALM_TO);

    always @(posedge i_clk) begin : driver
        t_sample s;
        if (!i_rst_n) begin
            in_ch.valid  <= 1'b0;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_samples.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    s = pending_samples.pop_front();
                    in_ch.elevation   <= s.elevation;
                    in_ch.route_start <= s.route_start;
                    in_ch.valid       <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_stats exp_r;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                stats_due.push_back(track_sample(in_ch.elevation, in_ch.route_start));
                n_sent <= n_sent + 1;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (stats_due.size() == 0) begin
                    $error("result with no pending request");
                    n_errors++;
                end else begin
                    exp_r = stats_due.pop_front();
                    if (out_ch.max_elevation !== exp_r.max_elevation) begin
                        $error("max_elevation: expected %0d, got %0d",
                               exp_r.max_elevation, out_ch.max_elevation);
                        n_errors++;
                    end
                    if (out_ch.gain_total !== exp_r.gain_total) begin
                        $error("gain_total: expected %0d, got %0d",
                               exp_r.gain_total, out_ch.gain_total);
                        n_errors++;
                    end
                    if (out_ch.loss_total !== exp_r.loss_total) begin
                        $error("loss_total: expected %0d, got %0d",
                               exp_r.loss_total, out_ch.loss_total);
                        n_errors++;
                    end
                    if (out_ch.averaging_active !== exp_r.averaging_active) begin
                        $error("averaging_active: expected %0b, got %0b",
                               exp_r.averaging_active, out_ch.averaging_active);
                        n_errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.elevation    = '0;
        in_ch.route_start  = 1'b0;
        out_ch.ready       = 1'b0;
        n_errors           = 0;
        n_sent             = 0;
        idle_cycles        = 0;
        restart_route();

        // first route after reset runs without a start flag
        add_sample(-524288, 1'b0);
        add_sample(524287, 1'b0);
        add_sample(-524288, 1'b0);
        add_sample(524287, 1'b0);
        add_sample(-524288, 1'b0);
        add_sample(524287, 1'b0);
        add_sample(-524288, 1'b0);
        add_sample(524287, 1'b0);
        add_sample(-9, 1'b1);
        add_sample(-8, 1'b0);
        add_sample(-7, 1'b1);
        add_sample(100, 1'b1);
        for (int k = 0; k < 8; k++) add_sample(100, 1'b0);
        add_sample(524287, 1'b0);
        add_sample(-524288, 1'b0);
        add_sample(0, 1'b1);
        add_sample(-1, 1'b0);
        while (pending_samples.size() < N_RANDOM + 22) add_route();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_samples.size() > 0 || in_ch.valid || stats_due.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
